// ----- rtl/core/cfir_pkg.sv -----
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants of the complex-sample FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

	localparam int SAMPLE_W      = 16;   // Q1.15 samples, taps and outputs
	localparam int GAIN_W        = 16;   // unsigned Q8.8 gain
	localparam int TAP_IDX_W     = 6;
	localparam int NUM_TAPS_DEF  = 64;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	// Opcode of an input request.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clr;   // start a new sum
		logic vld;   // read data of one tap is present this cycle
	} mac_ctrl_t;

endpackage

// ----- rtl/core/cfir_ram.sv -----
// ----------------------------------------------------------------------------
// cfir_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/cfir_mac.sv -----
// ----------------------------------------------------------------------------
// cfir_mac
// Shared complex-by-real multiply-accumulate unit, one tap per cycle.
// ----------------------------------------------------------------------------
module cfir_mac #(
	parameter int ACC_W = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfir_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] din_re,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] din_im,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] weight,
	output logic signed [ACC_W-1:0]             acc_re,
	output logic signed [ACC_W-1:0]             acc_im,
	output logic                                busy
);

	import cfir_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_W;

	logic signed [PROD_W-1:0] prod_re_s2;
	logic signed [PROD_W-1:0] prod_im_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;

	always_ff @(posedge clk) begin
		prod_re_s2 <= din_re * weight;
		prod_im_s2 <= din_im * weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			vld_s2 <= ctrl.vld;
			if (ctrl.clr) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (vld_s2) begin
				acc_re_q <= acc_re_q + {{(ACC_W-PROD_W){prod_re_s2[PROD_W-1]}}, prod_re_s2};
				acc_im_q <= acc_im_q + {{(ACC_W-PROD_W){prod_im_s2[PROD_W-1]}}, prod_im_s2};
			end
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;
	assign busy   = vld_s2;

endmodule

// ----- rtl/core/complex_fir_filter.sv -----
// ----------------------------------------------------------------------------
// complex_fir_filter
// Direct-form FIR filter for complex Q1.15 samples with real Q1.15 taps.
//
// Input requests arrive on in_valid/in_ready. A request with op = load writes
// one tap weight and leaves in_ready high; a tap_index at or beyond NUM_TAPS is
// dropped. A request with op = filter shifts the sample into the delay line
// and gives one result on out_valid/out_ready: the tap sum scaled by the Q8.8
// gain (cfg_we/cfg_wdata), rounded half up and saturated to Q1.15.
// While a filter request runs, in_ready is low: one shared complex
// multiply-accumulate walks the taps, one tap per cycle, out of the
// delay and tap memories, and then one shared multiplier scales both sums.
// The result enters the output register in the same cycle as in_ready
// returns, so no new sample is taken while one is being filtered.
// After reset the block writes zeros to both memories with in_ready low;
// the gain returns to 1.0. Results sit in an output register;
// a new request may be accepted while a result waits, and the block holds
// its next result until the receiver has taken the previous one.
// ----------------------------------------------------------------------------
module complex_fir_filter #(
	parameter int NUM_TAPS = cfir_pkg::NUM_TAPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cfir_pkg::GAIN_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [cfir_pkg::TAP_IDX_W-1:0]       tap_index,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] tap_weight,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] sample_re,
	input  logic signed [cfir_pkg::SAMPLE_W-1:0] sample_im,
	input  logic                                 batch_last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cfir_pkg::SAMPLE_W-1:0] out_re,
	output logic signed [cfir_pkg::SAMPLE_W-1:0] out_im,
	output logic                                 clipped,
	output logic                                 block_end
);

	import cfir_pkg::*;

	localparam int AW     = $clog2(NUM_TAPS);
	localparam int CW     = (AW > TAP_IDX_W) ? AW + 1 : TAP_IDX_W + 1;
	localparam int ACC_W  = 2 * SAMPLE_W + AW;
	localparam int SP_W   = ACC_W + GAIN_W + 1;
	localparam int RND_SH = 23;
	localparam logic [AW-1:0]        LAST_TAP = AW'(NUM_TAPS - 1);
	localparam logic signed [SP_W:0] RND_ADD  = (SP_W+1)'(2 ** (RND_SH - 1));
	localparam logic signed [SP_W:0] Q_MAX    = (SP_W+1)'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [SP_W:0] Q_MIN    = ~Q_MAX;

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_RUN      = 7'b0000100,
		S_DRAIN    = 7'b0001000,
		S_SCALE_RE = 7'b0010000,
		S_SCALE_IM = 7'b0100000,
		S_FINISH   = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              cnt_q;
	logic [AW-1:0]              wp_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       last_q;
	logic                       rd_s1;
	logic signed [SP_W-1:0]     sprod_q;
	logic signed [SAMPLE_W-1:0] res_re_q;
	logic                       sat_re_q;
	logic                       out_valid_q;

	logic                       accept;
	logic                       acc_load;
	logic                       acc_filter;
	logic [CW-1:0]              tidx_ext;
	logic                       tidx_ok;
	logic                       dly_we;
	logic [AW-1:0]              dly_waddr;
	logic [2*SAMPLE_W-1:0]      dly_wdata;
	logic [AW-1:0]              dly_raddr;
	logic [2*SAMPLE_W-1:0]      dly_rdata;
	logic [AW:0]                wrap_sum;
	logic                       tap_we;
	logic [AW-1:0]              tap_waddr;
	logic [SAMPLE_W-1:0]        tap_wdata;
	logic [AW-1:0]              tap_raddr;
	logic [SAMPLE_W-1:0]        tap_rdata;
	mac_ctrl_t                  mac_ctrl;
	logic signed [ACC_W-1:0]    acc_re;
	logic signed [ACC_W-1:0]    acc_im;
	logic                       mac_busy;
	logic signed [ACC_W-1:0]    scale_in;
	logic signed [SP_W-1:0]     scale_prod;
	logic signed [SP_W:0]       rnd_t;
	logic signed [SP_W:0]       rnd_q;
	logic                       sat_hi;
	logic                       sat_lo;
	logic signed [SAMPLE_W-1:0] rnd_val;
	logic                       fin_load;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign acc_load   = accept && (op == OP_LOAD);
	assign acc_filter = accept && (op == OP_FILTER);

	assign tidx_ext = CW'(tap_index);
	assign tidx_ok  = (tidx_ext < CW'(NUM_TAPS));

	// Both memories are written with zeros while clearing after reset.
	always_comb begin
		if (state_q == S_CLEAR) begin
			dly_we    = 1'b1;
			dly_waddr = cnt_q;
			dly_wdata = '0;
			tap_we    = 1'b1;
			tap_waddr = cnt_q;
			tap_wdata = '0;
		end else begin
			dly_we    = acc_filter;
			dly_waddr = wp_q;
			dly_wdata = {sample_re, sample_im};
			tap_we    = acc_load && tidx_ok;
			tap_waddr = tidx_ext[AW-1:0];
			tap_wdata = tap_weight;
		end
	end

	// The delay line is a ring: the sample of age cnt_q sits cnt_q entries
	// behind the newest, and meets tap NUM_TAPS-1-cnt_q.
	assign wrap_sum  = {1'b0, wp_q} + (AW+1)'(NUM_TAPS) - {1'b0, cnt_q};
	assign dly_raddr = (wp_q >= cnt_q) ? (wp_q - cnt_q) : wrap_sum[AW-1:0];
	assign tap_raddr = LAST_TAP - cnt_q;

	cfir_ram #(
		.WIDTH(2 * SAMPLE_W),
		.DEPTH(NUM_TAPS)
	) u_dly_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (dly_waddr),
		.wdata (dly_wdata),
		.raddr (dly_raddr),
		.rdata (dly_rdata)
	);

	cfir_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(NUM_TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata (tap_wdata),
		.raddr (tap_raddr),
		.rdata (tap_rdata)
	);

	assign mac_ctrl.clr = acc_filter;
	assign mac_ctrl.vld = rd_s1;

	cfir_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.din_re (dly_rdata[2*SAMPLE_W-1:SAMPLE_W]),
		.din_im (dly_rdata[SAMPLE_W-1:0]),
		.weight (tap_rdata),
		.acc_re (acc_re),
		.acc_im (acc_im),
		.busy   (mac_busy)
	);

	// One gain multiplier serves the real sum and then the imaginary sum.
	assign scale_in   = (state_q == S_SCALE_RE) ? acc_re : acc_im;
	assign scale_prod = scale_in * signed'({1'b0, gain_q});

	assign rnd_t   = {sprod_q[SP_W-1], sprod_q} + RND_ADD;
	assign rnd_q   = rnd_t >>> RND_SH;
	assign sat_hi  = (rnd_q > Q_MAX);
	assign sat_lo  = (rnd_q < Q_MIN);
	assign rnd_val = sat_hi ? Q_MAX[SAMPLE_W-1:0] :
	                 sat_lo ? Q_MIN[SAMPLE_W-1:0] : rnd_q[SAMPLE_W-1:0];

	assign fin_load = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (acc_filter) begin
			last_q <= batch_last;
		end
		if (state_q == S_SCALE_RE || state_q == S_SCALE_IM) begin
			sprod_q <= scale_prod;
		end
		if (state_q == S_SCALE_IM) begin
			res_re_q <= rnd_val;
			sat_re_q <= sat_hi || sat_lo;
		end
		if (fin_load) begin
			out_re    <= res_re_q;
			out_im    <= rnd_val;
			clipped   <= sat_re_q || sat_hi || sat_lo;
			block_end <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			wp_q        <= '0;
			gain_q      <= GAIN_RESET;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			rd_s1 <= (state_q == S_RUN);
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST_TAP) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (acc_filter) begin
						cnt_q   <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (cnt_q == LAST_TAP) begin
						cnt_q   <= '0;
						wp_q    <= (wp_q == LAST_TAP) ? '0 : wp_q + 1'b1;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!rd_s1 && !mac_busy) begin
						state_q <= S_SCALE_RE;
					end
				end
				S_SCALE_RE: begin
					state_q <= S_SCALE_IM;
				end
				S_SCALE_IM: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// The tap pipeline must be empty before the sums are scaled.
	a_drained_before_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE_RE) |-> (!rd_s1 && !mac_busy))
		else $error("scaling started with taps still in flight");

	// An accepted sample starts the tap walk at the newest entry.
	a_filter_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		acc_filter |=> (state_q == S_RUN && cnt_q == '0))
		else $error("filter request did not start the tap walk");

	// The ring pointer never leaves the delay line.
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_TAP)
		else $error("delay line pointer out of range");

	// A new result comes only out of the finishing step.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside the finishing step");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for complex_fir_filter. Tap loads and complex samples
// go on the request channel, with random gaps and receiver stalls in paced
// phases. Accepted requests update a local model of the taps or the delay
// line; gain writes update the modelled gain. Each filtered output is checked
// against the oldest predicted result. The run covers several gain settings,
// including the extremes, and tap sets from full scale to very small.
// ----------------------------------------------------------------------------
module testbench;
	import cfir_pkg::*;

	localparam int NUM_TAPS    = NUM_TAPS_DEF;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef struct {
		logic                       op;
		logic [TAP_IDX_W-1:0]       idx;
		logic signed [SAMPLE_W-1:0] weight;
		logic signed [SAMPLE_W-1:0] s_re;
		logic signed [SAMPLE_W-1:0] s_im;
		logic                       last;
	} fir_request_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       clip;
		logic                       last;
	} filt_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [GAIN_W-1:0]          cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       op = OP_LOAD;
	logic [TAP_IDX_W-1:0]       tap_index = '0;
	logic signed [SAMPLE_W-1:0] tap_weight = '0;
	logic signed [SAMPLE_W-1:0] sample_re = '0;
	logic signed [SAMPLE_W-1:0] sample_im = '0;
	logic                       batch_last = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] out_re;
	logic signed [SAMPLE_W-1:0] out_im;
	logic                       clipped;
	logic                       block_end;

	// Local copy of the filter state.
	logic [GAIN_W-1:0]          gain_model = GAIN_RESET;
	logic signed [SAMPLE_W-1:0] tap_model      [NUM_TAPS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] delay_re_model [NUM_TAPS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] delay_im_model [NUM_TAPS] = '{default: '0};

	fir_request_t request_q [$];
	filt_result_t expected_q [$];
	fir_request_t next_req;
	filt_result_t want_res;

	bit paced = 1'b1;
	bit req_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int n_loads = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_clipped = 0;
	int n_gain_settings = 1;

	complex_fir_filter #(.NUM_TAPS(NUM_TAPS)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.tap_index  (tap_index),
		.tap_weight (tap_weight),
		.sample_re  (sample_re),
		.sample_im  (sample_im),
		.batch_last (batch_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_re     (out_re),
		.out_im     (out_im),
		.clipped    (clipped),
		.block_end  (block_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Scale a Q8.30 sum by the Q8.8 gain, round half up to Q1.15 and clamp.
	function automatic logic signed [SAMPLE_W-1:0] scale_to_q15(input longint sum,
			inout bit sat);
		longint q;
		q = (sum * longint'(gain_model) + (longint'(1) << 22)) >>> 23;
		if (q > 32767) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (q < -32768) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return q[SAMPLE_W-1:0];
	endfunction

	function automatic filt_result_t run_filter(input logic signed [SAMPLE_W-1:0] s_re,
			input logic signed [SAMPLE_W-1:0] s_im, input logic last);
		longint       acc_re;
		longint       acc_im;
		bit           sat;
		filt_result_t res;
		acc_re = 0;
		acc_im = 0;
		sat = 1'b0;
		for (int i = 0; i < NUM_TAPS - 1; i++) begin
			delay_re_model[i] = delay_re_model[i+1];
			delay_im_model[i] = delay_im_model[i+1];
		end
		delay_re_model[NUM_TAPS-1] = s_re;
		delay_im_model[NUM_TAPS-1] = s_im;
		for (int i = 0; i < NUM_TAPS; i++) begin
			acc_re += longint'(delay_re_model[i]) * longint'(tap_model[i]);
			acc_im += longint'(delay_im_model[i]) * longint'(tap_model[i]);
		end
		res.re   = scale_to_q15(acc_re, sat);
		res.im   = scale_to_q15(acc_im, sat);
		res.clip = sat;
		res.last = last;
		return res;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 150);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_q15(input int shift);
		logic signed [SAMPLE_W-1:0] v;
		v = SAMPLE_W'($urandom());
		return v >>> shift;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		if ($urandom_range(0, 15) != 0)
			return rand_q15($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	// Sample fields of a load are ignored by the block, so they carry noise.
	function automatic void queue_load(input logic [TAP_IDX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] w);
		request_q.push_back('{OP_LOAD, idx, w, SAMPLE_W'($urandom()),
			SAMPLE_W'($urandom()), 1'($urandom())});
	endfunction

	function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] re,
			input logic signed [SAMPLE_W-1:0] im, input logic last);
		request_q.push_back('{OP_FILTER, TAP_IDX_W'($urandom()), SAMPLE_W'($urandom()),
			re, im, last});
	endfunction

	// Returns at a falling edge once every request is taken and every result is
	// back, plus enough cycles for a trailing tap load to finish. The check is
	// made at the rising edge, where the driven request has settled.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (request_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (NUM_TAPS + 8) @(negedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_gain_settings++;
	endtask

	task automatic run_phase(input logic [GAIN_W-1:0] g, input int count,
			input bit with_gaps);
		int shift;
		bit sparse;
		wait_drained();
		write_gain(g);
		paced  = with_gaps;
		shift  = $urandom_range(0, 9);
		sparse = $urandom_range(0, 1);
		// Usually a full tap set; sometimes only a few taps change over the old set.
		if ($urandom_range(0, 3) != 0) begin
			for (int i = 0; i < NUM_TAPS; i++)
				queue_load(TAP_IDX_W'(i),
					(sparse && $urandom_range(0, 2) == 0) ? '0 : rand_q15(shift));
		end else begin
			repeat (16)
				queue_load(TAP_IDX_W'($urandom_range(0, NUM_TAPS - 1)), rand_q15(shift));
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 19) == 0)
				queue_load(TAP_IDX_W'($urandom_range(0, NUM_TAPS - 1)),
					rand_q15($urandom_range(0, 9)));
			queue_sample(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
		end
	endtask

	// Request driver.
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_q.size() != 0) begin
				next_req = request_q.pop_front();
				in_valid   <= 1'b1;
				op         <= next_req.op;
				tap_index  <= next_req.idx;
				tap_weight <= next_req.weight;
				sample_re  <= next_req.s_re;
				sample_im  <= next_req.s_im;
				batch_last <= next_req.last;
				send_gap = paced ? gap_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (paced && $urandom_range(0, 7) == 0)
				stall_left = gap_len();
		end
	end

	// Prediction on accepted requests and checking of accepted results.
	always @(posedge clk) begin
		if (cfg_we)
			gain_model = cfg_wdata;
		if (in_valid && in_ready) begin
			req_taken = 1'b1;
			if (op == OP_FILTER) begin
				n_samples++;
				expected_q.push_back(run_filter(sample_re, sample_im, batch_last));
			end else begin
				n_loads++;
				if (tap_index < NUM_TAPS)
					tap_model[tap_index] = tap_weight;
			end
		end
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("output with no sample pending: re=%0d im=%0d",
					out_re, out_im));
			end else begin
				want_res = expected_q.pop_front();
				n_results++;
				if (want_res.clip)
					n_clipped++;
				if (out_re !== want_res.re || out_im !== want_res.im ||
						clipped !== want_res.clip || block_end !== want_res.last)
					report_mismatch($sformatf(
						"output %0d: got %0d/%0d clip=%b end=%b, want %0d/%0d clip=%b end=%b",
						n_results, out_re, out_im, clipped, block_end,
						want_res.re, want_res.im, want_res.clip, want_res.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d outputs outstanding.",
				cycle_count, expected_q.size());
			$display("FAIL complex_fir_filter");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset gain of 1.0: extreme taps at both ends
		// of the delay line, extreme samples, full-scale products that clip,
		// and a zeroed tap set.
		queue_load(TAP_IDX_W'(NUM_TAPS - 1), 16'sh7fff);
		queue_load(TAP_IDX_W'(0), 16'sh8000);
		queue_load(TAP_IDX_W'(NUM_TAPS - 2), 16'shffff);
		queue_load(TAP_IDX_W'(1), 16'sh4000);
		queue_sample(16'sh7fff, 16'sh8000, 1'b1);
		queue_sample(16'sh8000, 16'sh8000, 1'b0);
		queue_sample(16'sh0000, 16'sh0000, 1'b1);
		queue_sample(16'sh0001, 16'shffff, 1'b0);
		queue_sample(16'shffff, 16'sh0001, 1'b1);
		queue_load(TAP_IDX_W'(NUM_TAPS - 1), 16'sh8000);
		queue_sample(16'sh8000, 16'sh7fff, 1'b0);
		queue_sample(16'sh7fff, 16'sh7fff, 1'b1);
		queue_load(TAP_IDX_W'(NUM_TAPS - 1), 16'sh0000);
		queue_load(TAP_IDX_W'(NUM_TAPS - 2), 16'sh0000);
		queue_load(TAP_IDX_W'(0), 16'sh0000);
		queue_load(TAP_IDX_W'(1), 16'sh0000);
		queue_sample(16'sh3039, 16'shcfc7, 1'b0);
		queue_sample(16'sh8000, 16'sh7fff, 1'b1);

		run_phase(16'hffff, 240, 1'b1);
		run_phase(16'h0000, 160, 1'b0);
		run_phase(16'h0001, 220, 1'b1);
		run_phase(GAIN_W'($urandom_range(128, 1024)), 240, 1'b1);
		run_phase(GAIN_RESET, 240, 1'b0);
		run_phase(GAIN_W'($urandom()), 200, 1'b1);
		run_phase(GAIN_W'($urandom_range(32, 768)), 240, 1'b1);
		wait_drained();

		$display("Covered %0d requests: %0d tap loads and %0d samples over %0d gain settings.",
			n_loads + n_samples, n_loads, n_samples, n_gain_settings);
		$display("Checked %0d filtered outputs, %0d of them saturated.", n_results, n_clipped);
		if (mismatch_count == 0)
			$display("PASS complex_fir_filter");
		else
			$display("FAIL complex_fir_filter");
		$finish;
	end

endmodule
